FILE: sv/bmm_pkg.sv
// Shared types, constants and helpers for the banked memory map bus.
`timescale 1ns / 1ps
`default_nettype none
package bmm_pkg;

  localparam int RomBanksDef  = 128;
  localparam int WramBytesDef = 8192;
  localparam int VramBytes    = 8192;
  localparam int OamBytes     = 160;
  localparam int IoBytes      = 128;
  localparam int HramBytes    = 128;

  localparam int VramAw = $clog2(VramBytes);
  localparam int OamAw  = $clog2(OamBytes);
  localparam int IoAw   = $clog2(IoBytes);
  localparam int HramAw = $clog2(HramBytes);
  localparam int ClrAw  = VramAw;

  localparam int BankW  = 7;
  localparam int FetchW = 21;

  localparam logic [IoAw-1:0] BootCtrlIdx = 7'h50;

  typedef enum logic [1:0] {
    OpRdByte = 2'd0,
    OpRdHalf = 2'd1,
    OpWrByte = 2'd2,
    OpWrHalf = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    SrcNone,
    SrcRom,
    SrcVram,
    SrcWram,
    SrcOam,
    SrcIo,
    SrcHram
  } src_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StByte0,
    StByte1,
    StFinish
  } st_e;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] address;
    logic [15:0] write_data;
  } in_t;

  typedef struct packed {
    logic [15:0]       read_data;
    logic              fetch_external;
    logic              fetch_source;
    logic [FetchW-1:0] fetch_address;
  } out_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic access;
    logic hi;
    logic capture_lo;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic half;
    logic clr_last;
  } stat_t;

  localparam logic [15:0] IoPresent [8] = '{
    16'h80F7, 16'h7FDF, 16'h007F, 16'hFFFF, 16'h0FFF, 16'h0001, 16'h0000, 16'h0000
  };

  function automatic logic io_present_f(input logic [IoAw-1:0] idx);
    logic [15:0] row;
    row = IoPresent[idx[6:4]];
    return row[idx[3:0]];
  endfunction

endpackage
`default_nettype wire

FILE: sv/bmm_ctrl.sv
// Controller state machine sequencing the byte beats of one bus access.
`timescale 1ns / 1ps
`default_nettype none
module bmm_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  output logic           busy,
  input  bmm_pkg::stat_t stat_i,
  output bmm_pkg::cmd_t  cmd_o
);
  import bmm_pkg::*;

  st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (stat_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (start) state_d = StByte0;
      end
      StByte0: begin
        state_d = stat_i.half ? StByte1 : StFinish;
      end
      StByte1: begin
        state_d = StFinish;
      end
      StFinish: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
      end
      StIdle: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      StByte0: begin
        cmd_o.access = 1'b1;
      end
      StByte1: begin
        cmd_o.access     = 1'b1;
        cmd_o.hi         = 1'b1;
        cmd_o.capture_lo = 1'b1;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/bmm_datapath.sv
// Datapath: address decode, on-chip memories, bank register and result register.
`timescale 1ns / 1ps
`default_nettype none
module bmm_datapath #(
  parameter int ROM_BANKS      = bmm_pkg::RomBanksDef,
  parameter int WORK_RAM_BYTES = bmm_pkg::WramBytesDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [bmm_pkg::BankW-1:0]     cfg_wdata_i,
  input  bmm_pkg::in_t                 req_i,
  input  bmm_pkg::cmd_t                cmd_i,
  output bmm_pkg::stat_t               stat_o,
  output bmm_pkg::out_t                result_o,
  output logic                         valid_o
);
  import bmm_pkg::*;

  localparam int WramAw = $clog2(WORK_RAM_BYTES);

  logic [7:0] vram [VramBytes];
  logic [7:0] wram [WORK_RAM_BYTES];
  logic [7:0] oam  [OamBytes];
  logic [7:0] io   [IoBytes];
  logic [7:0] hram [HramBytes];

  logic [7:0] vram_rd_q, wram_rd_q, oam_rd_q, io_rd_q, hram_rd_q;

  op_e               op_q;
  logic [15:0]       addr_q;
  logic [15:0]       wdata_q;
  logic [BankW-1:0]  bank_q;
  logic              boot_off_q;
  logic [ClrAw-1:0]  clr_cnt_q;
  src_e              sel_q;
  logic [7:0]        lo_q;
  logic              fx_q, fs_q;
  logic [FetchW-1:0] fa_q;
  out_t              result_q;
  logic              valid_q;

  logic [15:0]       a;
  logic [7:0]        wbyte;
  logic              is_write;
  logic              bank_ok;
  src_e              src;
  logic              fsrc;
  logic [FetchW-1:0] faddr;
  logic [7:0]        byte_val;
  out_t              result_d;

  assign a        = cmd_i.hi ? addr_q + 16'd1 : addr_q;
  assign wbyte    = cmd_i.hi ? wdata_q[15:8] : wdata_q[7:0];
  assign is_write = op_q inside {OpWrByte, OpWrHalf};
  assign bank_ok  = 32'(bank_q) < ROM_BANKS;

  always_comb begin
    src   = SrcNone;
    fsrc  = 1'b0;
    faddr = '0;
    if (a < 16'h0100 && !boot_off_q) begin
      src   = SrcRom;
      faddr = FetchW'(a);
    end else if (a < 16'h4000) begin
      src   = SrcRom;
      fsrc  = 1'b1;
      faddr = FetchW'(a);
    end else if (a < 16'h8000) begin
      if (bank_ok) begin
        src   = SrcRom;
        fsrc  = 1'b1;
        faddr = {bank_q, a[13:0]};
      end
    end else if (a inside {[16'h8000:16'h9FFF]}) begin
      src = SrcVram;
    end else if (a inside {[16'hC000:16'hFDFF]}) begin
      src = SrcWram;
    end else if (a inside {[16'hFE00:16'hFE9F]}) begin
      src = SrcOam;
    end else if (a inside {[16'hFF00:16'hFF7F]}) begin
      if (io_present_f(a[IoAw-1:0])) src = SrcIo;
    end else if (a >= 16'hFF80) begin
      src = SrcHram;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      vram[clr_cnt_q[VramAw-1:0]] <= '0;
    end else if (cmd_i.access && is_write && src == SrcVram) begin
      vram[a[VramAw-1:0]] <= wbyte;
    end
    vram_rd_q <= vram[a[VramAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      wram[clr_cnt_q[WramAw-1:0]] <= '0;
    end else if (cmd_i.access && is_write && src == SrcWram) begin
      wram[a[WramAw-1:0]] <= wbyte;
    end
    wram_rd_q <= wram[a[WramAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (32'(clr_cnt_q) < OamBytes) oam[clr_cnt_q[OamAw-1:0]] <= '0;
    end else if (cmd_i.access && is_write && src == SrcOam) begin
      oam[a[OamAw-1:0]] <= wbyte;
    end
    oam_rd_q <= oam[a[OamAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      io[clr_cnt_q[IoAw-1:0]] <= '0;
    end else if (cmd_i.access && is_write && src == SrcIo) begin
      io[a[IoAw-1:0]] <= wbyte;
    end
    io_rd_q <= io[a[IoAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      hram[clr_cnt_q[HramAw-1:0]] <= '0;
    end else if (cmd_i.access && is_write && src == SrcHram) begin
      hram[a[HramAw-1:0]] <= wbyte;
    end
    hram_rd_q <= hram[a[HramAw-1:0]];
  end

  always_comb begin
    case (sel_q)
      SrcNone: byte_val = 8'hFF;
      SrcRom:  byte_val = 8'h00;
      SrcVram: byte_val = vram_rd_q;
      SrcWram: byte_val = wram_rd_q;
      SrcOam:  byte_val = oam_rd_q;
      SrcIo:   byte_val = io_rd_q;
      SrcHram: byte_val = hram_rd_q;
      default: byte_val = 8'hFF;
    endcase
  end

  always_comb begin
    result_d                = '0;
    result_d.fetch_external = fx_q;
    result_d.fetch_source   = fs_q;
    result_d.fetch_address  = fa_q;
    if (is_write) begin
      result_d.read_data = '0;
    end else if (op_q == OpRdHalf) begin
      result_d.read_data = {byte_val, lo_q};
    end else begin
      result_d.read_data = {8'h00, byte_val};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q     <= BankW'(1);
      boot_off_q <= 1'b0;
      clr_cnt_q  <= '0;
      valid_q    <= 1'b0;
      fx_q       <= 1'b0;
      sel_q      <= SrcNone;
    end else begin
      valid_q <= cmd_i.finish;
      if (cfg_we_i) bank_q <= cfg_wdata_i;
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + ClrAw'(1);
      if (cmd_i.load) fx_q <= 1'b0;
      if (cmd_i.access) begin
        sel_q <= src;
        if (!is_write && src == SrcRom && !fx_q) fx_q <= 1'b1;
        if (is_write && src == SrcIo && a[IoAw-1:0] == BootCtrlIdx) begin
          boot_off_q <= wbyte[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= req_i.opcode;
      addr_q  <= req_i.address;
      wdata_q <= req_i.write_data;
      fs_q    <= 1'b0;
      fa_q    <= '0;
    end
    if (cmd_i.access && !is_write && src == SrcRom && !fx_q) begin
      fs_q <= fsrc;
      fa_q <= faddr;
    end
    if (cmd_i.capture_lo) lo_q <= byte_val;
    if (cmd_i.finish) result_q <= result_d;
  end

  assign stat_o.half     = op_q inside {OpRdHalf, OpWrHalf};
  assign stat_o.clr_last = &clr_cnt_q;
  assign result_o        = result_q;
  assign valid_o         = valid_q;

endmodule
`default_nettype wire

FILE: sv/banked_memory_map_bus.sv
// Top level of the banked memory map bus: controller plus datapath.
//
//   channel   handshake          payload
//   request   start / busy       req_i    (opcode, address, write_data)
//   result    valid_o strobe     result_o (read_data, fetch_*)
//   config    cfg_we_i           cfg_wdata_i (rom_bank)
//
// A byte access runs through StByte0 and StFinish, a halfword access through
// StByte0, StByte1 and StFinish: each byte is one beat through the single-port
// memories, and StFinish registers the result. After reset a clearing pass
// zeroes all memories; busy stays high for its length. The strobe lasts one
// cycle and cannot be held off; the next access may start in that cycle.
`timescale 1ns / 1ps
`default_nettype none
module banked_memory_map_bus #(
  parameter int ROM_BANKS      = bmm_pkg::RomBanksDef,
  parameter int WORK_RAM_BYTES = bmm_pkg::WramBytesDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  output logic                     busy,
  input  bmm_pkg::in_t             req_i,
  output bmm_pkg::out_t            result_o,
  output logic                     valid_o,
  input  wire                      cfg_we_i,
  input  wire [bmm_pkg::BankW-1:0] cfg_wdata_i
);
  import bmm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bmm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bmm_datapath #(
    .ROM_BANKS      (ROM_BANKS),
    .WORK_RAM_BYTES (WORK_RAM_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o),
    .valid_o     (valid_o)
  );

`ifndef NO_ASSERTIONS
  a_byte_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !req_i.opcode[0] |-> ##3 valid_o)
    else $error("byte access result not on time");

  a_half_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.opcode[0] |-> ##4 valid_o)
    else $error("halfword access result not on time");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy && $past(busy))
    else $error("result strobe without a finished access");

  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(req_i.opcode[1] && start && !busy, 3) |-> result_o == '0)
    else $error("byte write returned non-zero result");
`endif

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the banked memory map bus: directed probes, then random accesses.
`timescale 1ns / 1ps
module testbench;
  import bmm_pkg::*;

  localparam int StallLimit  = 40000;
  localparam int DrainCycles = 8;
  localparam int MaxShown    = 10;
  localparam int Phases      = 6;
  localparam int PhaseItems  = 262;
  localparam int ProbeCount  = 25;
  localparam int BootCtrl    = 'h50;

  typedef enum logic [2:0] {
    MapOpen, MapBoot, MapCart, MapVram, MapWram, MapOam, MapIo, MapHram
  } map_e;

  typedef struct packed {
    map_e              kind;
    logic [FetchW-1:0] fetch;
    logic [12:0]       idx;
  } slot_t;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] address;
    logic [15:0] write_data;
    logic        known;
    out_t        want;
  } probe_t;

  localparam out_t NoReply = '0;

  localparam logic [15:0] IoMap [8] = '{
    16'h80F7, 16'h7FDF, 16'h007F, 16'hFFFF, 16'h0FFF, 16'h0001, 16'h0000, 16'h0000
  };

  localparam logic [15:0] RegionEdges [11] = '{
    16'h00FF, 16'h3FFF, 16'h7FFF, 16'h9FFF, 16'hBFFF, 16'hDFFF,
    16'hFDFF, 16'hFE9F, 16'hFEFF, 16'hFF7F, 16'hFFFF
  };

  localparam logic [15:0] WramWindows [4] = '{16'hC000, 16'hE000, 16'hDFE0, 16'hFDE0};

  localparam probe_t Probes [ProbeCount] = '{
    '{OpRdByte, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 21'h000000}},
    '{OpRdHalf, 16'h00FF, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 21'h0000FF}},
    '{OpRdByte, 16'h4000, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b1, 21'h004000}},
    '{OpRdHalf, 16'h3FFF, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b1, 21'h003FFF}},
    '{OpRdByte, 16'hA000, 16'h0000, 1'b1, '{16'h00FF, 1'b0, 1'b0, 21'h000000}},
    '{OpRdHalf, 16'hFEA0, 16'h0000, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 21'h000000}},
    '{OpRdHalf, 16'hFF00, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 21'h000000}},
    '{OpRdByte, 16'hFF03, 16'h0000, 1'b1, '{16'h00FF, 1'b0, 1'b0, 21'h000000}},
    '{OpWrHalf, 16'hFFFF, 16'hA55A, 1'b1, NoReply},
    '{OpRdHalf, 16'hFFFF, 16'h0000, 1'b1, '{16'h005A, 1'b1, 1'b0, 21'h000000}},
    '{OpWrByte, 16'hC000, 16'h12FF, 1'b1, NoReply},
    '{OpRdByte, 16'hE000, 16'h0000, 1'b0, NoReply},
    '{OpWrHalf, 16'h9FFF, 16'h1234, 1'b1, NoReply},
    '{OpRdHalf, 16'h9FFF, 16'h0000, 1'b0, NoReply},
    '{OpWrHalf, 16'hFE9F, 16'hBEEF, 1'b1, NoReply},
    '{OpRdHalf, 16'hFE9F, 16'h0000, 1'b0, NoReply},
    '{OpWrHalf, 16'hFF4F, 16'h01C3, 1'b1, NoReply},
    '{OpRdByte, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b1, 21'h000000}},
    '{OpRdHalf, 16'h00FF, 16'h0000, 1'b0, NoReply},
    '{OpRdByte, 16'hFF50, 16'h0000, 1'b0, NoReply},
    '{OpRdHalf, 16'h7FFF, 16'h0000, 1'b0, NoReply},
    '{OpWrByte, 16'hFF50, 16'hFF00, 1'b1, NoReply},
    '{OpRdHalf, 16'hFF7F, 16'h0000, 1'b0, NoReply},
    '{OpWrHalf, 16'hFFFE, 16'hFFFF, 1'b1, NoReply},
    '{OpRdHalf, 16'hFFFE, 16'h0000, 1'b0, NoReply}
  };

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  in_t               req_i       = '0;
  out_t              result_o;
  logic              valid_o;
  logic              cfg_we_i    = 1'b0;
  logic [BankW-1:0]  cfg_wdata_i = '0;

  logic [7:0]        vram_copy [8192] = '{default: 8'h00};
  logic [7:0]        wram_copy [8192] = '{default: 8'h00};
  logic [7:0]        oam_copy  [160]  = '{default: 8'h00};
  logic [7:0]        io_copy   [128]  = '{default: 8'h00};
  logic [7:0]        hram_copy [128]  = '{default: 8'h00};
  logic [BankW-1:0]  bank_sel = 7'd1;

  out_t              awaited_replies [$];
  int unsigned       fault_count;
  int unsigned       quiet_cycles;
  int unsigned       sender_idle_pct;

  banked_memory_map_bus dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .result_o   (result_o),
    .valid_o    (valid_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic slot_t map_byte(logic [15:0] a);
    slot_t s;
    s = '0;
    s.kind = MapOpen;
    if (a < 16'h0100 && !io_copy[BootCtrl][0]) begin
      s.kind  = MapBoot;
      s.fetch = FetchW'(a);
    end else if (a < 16'h4000) begin
      s.kind  = MapCart;
      s.fetch = FetchW'(a);
    end else if (a < 16'h8000) begin
      if (int'(bank_sel) < RomBanksDef) begin
        s.kind  = MapCart;
        s.fetch = {bank_sel, a[13:0]};
      end
    end else if (a < 16'hA000) begin
      s.kind = MapVram;
      s.idx  = a[12:0];
    end else if (a < 16'hC000) begin
      s.kind = MapOpen;
    end else if (a < 16'hFE00) begin
      s.kind = MapWram;
      s.idx  = a[12:0];
    end else if (a < 16'hFEA0) begin
      s.kind = MapOam;
      s.idx  = 13'(a[7:0]);
    end else if (a < 16'hFF00) begin
      s.kind = MapOpen;
    end else if (a < 16'hFF80) begin
      if (IoMap[a[6:4]][a[3:0]]) begin
        s.kind = MapIo;
        s.idx  = 13'(a[6:0]);
      end
    end else begin
      s.kind = MapHram;
      s.idx  = 13'(a[6:0]);
    end
    return s;
  endfunction

  function automatic logic [7:0] byte_at(slot_t s);
    case (s.kind)
      MapOpen: return 8'hFF;
      MapVram: return vram_copy[s.idx];
      MapWram: return wram_copy[s.idx];
      MapOam:  return oam_copy[s.idx];
      MapIo:   return io_copy[s.idx];
      MapHram: return hram_copy[s.idx];
      default: return 8'h00;
    endcase
  endfunction

  function automatic void store_byte(slot_t s, logic [7:0] v);
    case (s.kind)
      MapVram: vram_copy[s.idx] = v;
      MapWram: wram_copy[s.idx] = v;
      MapOam:  oam_copy[s.idx]  = v;
      MapIo:   io_copy[s.idx]   = v;
      MapHram: hram_copy[s.idx] = v;
      default: ;
    endcase
  endfunction

  function automatic out_t access_outcome(in_t beat);
    out_t        r;
    slot_t       lo;
    slot_t       hi;
    slot_t       rom;
    logic [15:0] next_addr;
    logic        half;
    r         = '0;
    next_addr = beat.address + 16'd1;
    half      = (beat.opcode == OpRdHalf);
    case (beat.opcode)
      OpRdByte, OpRdHalf: begin
        lo = map_byte(beat.address);
        hi = map_byte(next_addr);
        r.read_data[7:0] = byte_at(lo);
        if (half) r.read_data[15:8] = byte_at(hi);
        if (lo.kind inside {MapBoot, MapCart}) begin
          rom = lo;
          r.fetch_external = 1'b1;
        end else if (half && hi.kind inside {MapBoot, MapCart}) begin
          rom = hi;
          r.fetch_external = 1'b1;
        end
        if (r.fetch_external) begin
          r.fetch_source  = (rom.kind == MapCart);
          r.fetch_address = rom.fetch;
        end
      end
      OpWrByte: store_byte(map_byte(beat.address), beat.write_data[7:0]);
      default: begin
        store_byte(map_byte(beat.address), beat.write_data[7:0]);
        store_byte(map_byte(next_addr), beat.write_data[15:8]);
      end
    endcase
    return r;
  endfunction

  task automatic drive_access(in_t beat);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= beat;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_bank(logic [BankW-1:0] bank);
    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bank;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    bank_sel = bank;
  endtask

  always @(negedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && valid_o) begin
      if (awaited_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= MaxShown)
          $display("unexpected result: rd=%h fx=%b fs=%b fa=%h", result_o.read_data,
                   result_o.fetch_external, result_o.fetch_source, result_o.fetch_address);
      end else begin
        want = awaited_replies.pop_front();
        if (result_o.read_data !== want.read_data ||
            result_o.fetch_external !== want.fetch_external ||
            result_o.fetch_source !== want.fetch_source ||
            result_o.fetch_address !== want.fetch_address) begin
          fault_count++;
          if (fault_count <= MaxShown)
            $display("mismatch: expected rd=%h fx=%b fs=%b fa=%h, got rd=%h fx=%b fs=%b fa=%h",
                     want.read_data, want.fetch_external, want.fetch_source,
                     want.fetch_address, result_o.read_data, result_o.fetch_external,
                     result_o.fetch_source, result_o.fetch_address);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_t              beat;
    out_t             outcome;
    logic [BankW-1:0] bank;
    fault_count     = 0;
    quiet_cycles    = 0;
    sender_idle_pct = 19;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < ProbeCount; i++) begin
      beat.opcode     = Probes[i].opcode;
      beat.address    = Probes[i].address;
      beat.write_data = Probes[i].write_data;
      drive_access(beat);
      outcome = access_outcome(beat);
      awaited_replies.push_back(Probes[i].known ? Probes[i].want : outcome);
    end

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0:       bank = '0;
        1, 4:    bank = '1;
        5:       bank = 7'd1;
        default: bank = BankW'($urandom_range(2, 126));
      endcase
      set_bank(bank);
      sender_idle_pct = (p < 2) ? 19 : (p < 4) ? 84 : 0;
      for (int n = 0; n < PhaseItems; n++) begin
        beat.opcode     = op_e'($urandom_range(0, 3));
        beat.write_data = 16'($urandom);
        case ($urandom_range(0, 9))
          0: beat.address = 16'($urandom);
          1: beat.address = RegionEdges[$urandom_range(0, 10)] + 16'($urandom_range(0, 1));
          2: beat.address = 16'($urandom_range(0, 'h1FF));
          3: beat.address = 16'($urandom_range('h3FF0, 'h7FFF));
          4: beat.address = ($urandom_range(0, 1) ? 16'h8000 : 16'h9FE0)
                            + 16'($urandom_range(0, 31));
          5: beat.address = WramWindows[$urandom_range(0, 3)] + 16'($urandom_range(0, 31));
          6: beat.address = 16'hFE00 + 16'($urandom_range(0, 255));
          7, 8: beat.address = 16'hFF00 + 16'($urandom_range(0, 255));
          default: beat.address = 16'hFF50;
        endcase
        if ($urandom_range(0, 63) == 0) begin
          start <= 1'b0;
          @(posedge clk_i);
          while (awaited_replies.size() != 0) @(posedge clk_i);
        end
        drive_access(beat);
        awaited_replies.push_back(access_outcome(beat));
      end
    end

    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
sv/bmm_pkg.sv
sv/bmm_ctrl.sv
sv/bmm_datapath.sv
sv/banked_memory_map_bus.sv
sim/testbench.sv
